// ===== rtl/ssw_pkg.sv =====
// Shared types and constants of the separable spectral weighting unit.
// Depends on nothing; the files that use it refer to it by scoped names.
`timescale 1ns / 1ps
`default_nettype none

package ssw_pkg;

    // Fixed field widths
    localparam int SAMPLE_W    = 32;
    localparam int WEIGHT_W    = 24;
    localparam int WIDX_W      = 8;
    localparam int SIDE_CFG_W  = 7;
    localparam int LARGE_CFG_W = 9;
    localparam int CFG_DATA_W  = 32;
    localparam int CFG_ADDR_W  = 3;

    // Datapath widths: 32x24 product, sum of two, plus rounding headroom
    localparam int PROD_W = SAMPLE_W + WEIGHT_W;
    localparam int SUM_W  = PROD_W + 1;
    localparam int RND_W  = SUM_W + 1;

    localparam logic [SAMPLE_W-1:0] SAMPLE_MAX = 32'h7FFF_FFFF;
    localparam logic [SAMPLE_W-1:0] SAMPLE_MIN = 32'h8000_0000;

    // Register reset values
    localparam logic [SIDE_CFG_W-1:0]  SIDE_RESET  = 7'd16;
    localparam logic [LARGE_CFG_W-1:0] LARGE_RESET = 9'd64;

    // Command queue between front and back end
    localparam int QUEUE_DEPTH = 4;

    // Queue entry: two data words, three kernel slots, last, load_ok, op
    localparam int ENTRY_FIXED_W = 2 * SAMPLE_W + 3;

    // Three complex products per sample: fast, slow, middle
    localparam int          NUM_PASSES = 3;
    localparam logic [1:0]  LAST_PASS  = 2'd2;

    typedef enum logic [0:0] {
        REG_SIDE  = 1'b0,
        REG_LARGE = 1'b1
    } cfg_reg_t;

    typedef enum logic [0:0] {
        OP_LOAD   = 1'b0,
        OP_WEIGHT = 1'b1
    } op_t;

    typedef enum logic [2:0] {
        BK_IDLE,
        BK_READ,
        BK_MUL,
        BK_ADD,
        BK_RND,
        BK_DONE
    } back_state_t;

    typedef struct packed {
        logic [SAMPLE_W-1:0] value;
        logic                clip;
    } round_t;

endpackage

`default_nettype wire

// ===== rtl/ssw_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// Self-contained; used for the kernel spectrum store.
`timescale 1ns / 1ps
`default_nettype none

module ssw_ram #(
    parameter int WIDTH = 48,
    parameter int DEPTH = 256
) (
    input  wire logic                     aclk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output      logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

// ===== rtl/ssw_queue.sv =====
// Short first-in first-out command queue in flip-flops.
// Decouples the front end from the back end; does not depend on ssw_pkg.
`timescale 1ns / 1ps
`default_nettype none

module ssw_queue #(
    parameter int WIDTH = 91,
    parameter int DEPTH = 4
) (
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire logic             push,
    input  wire logic [WIDTH-1:0] push_data,
    output      logic             full,
    input  wire logic             pop,
    output      logic [WIDTH-1:0] pop_data,
    output      logic             empty
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] entry_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;

    function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
        return (p == PTR_W'(DEPTH - 1)) ? '0 : p + PTR_W'(1);
    endfunction

    assign full     = (count_reg == CNT_W'(DEPTH));
    assign empty    = (count_reg == '0);
    assign pop_data = entry_reg[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = push ? ptr_inc(wr_ptr_reg) : wr_ptr_reg;
        rd_ptr_next = pop  ? ptr_inc(rd_ptr_reg) : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop) begin
            count_next = count_reg + CNT_W'(1);
        end else if (pop && !push) begin
            count_next = count_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            entry_reg[wr_ptr_reg] <= push_data;
        end
    end

    // A push into a full queue would overwrite a pending command.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (full && !pop) |-> !push)
        else $error("ssw_queue: push into full queue");

endmodule

`default_nettype wire

// ===== rtl/ssw_front.sv =====
// Front end: accepts requests, tracks the volume position and resolves the
// three kernel slots of each sample. Depends on ssw_pkg.
`timescale 1ns / 1ps
`default_nettype none

module ssw_front #(
    parameter int MAX_SIDE   = 64,
    parameter int MAX_KERNEL = 256
) (
    input  wire logic                                aclk,
    input  wire logic                                aresetn,
    input  wire logic                                restart,
    input  wire logic [ssw_pkg::SIDE_CFG_W-1:0]      side_length,
    input  wire logic [ssw_pkg::LARGE_CFG_W-1:0]     large_length,
    input  wire logic                                s_valid,
    output      logic                                s_ready,
    input  wire logic                                s_operation,
    input  wire logic [ssw_pkg::WIDX_W-1:0]          s_weight_index,
    input  wire logic signed [ssw_pkg::WEIGHT_W-1:0] s_weight_re,
    input  wire logic signed [ssw_pkg::WEIGHT_W-1:0] s_weight_im,
    input  wire logic signed [ssw_pkg::SAMPLE_W-1:0] s_sample_re,
    input  wire logic signed [ssw_pkg::SAMPLE_W-1:0] s_sample_im,
    input  wire logic                                q_full,
    output      logic                                q_push,
    output      logic [ssw_pkg::ENTRY_FIXED_W + 3*$clog2(MAX_KERNEL)-1:0] q_data
);

    localparam int AW = $clog2(MAX_KERNEL);
    localparam int PW = $clog2(MAX_SIDE);
    localparam int KW = $clog2(MAX_KERNEL + 1);
    localparam int SW = $clog2(MAX_SIDE + 1);
    localparam int CW0 = (KW > SW) ? KW : SW;
    localparam int CW = (CW0 > ssw_pkg::LARGE_CFG_W) ? CW0 : ssw_pkg::LARGE_CFG_W;

    localparam int OFF_IM   = 0;
    localparam int OFF_RE   = ssw_pkg::SAMPLE_W;
    localparam int OFF_S0   = 2 * ssw_pkg::SAMPLE_W;
    localparam int OFF_S1   = OFF_S0 + AW;
    localparam int OFF_S2   = OFF_S1 + AW;
    localparam int OFF_LAST = OFF_S2 + AW;
    localparam int OFF_OK   = OFF_LAST + 1;
    localparam int OFF_OP   = OFF_OK + 1;

    logic [PW-1:0] pos_fast_reg, pos_fast_next;
    logic [PW-1:0] pos_mid_reg, pos_mid_next;
    logic [PW-1:0] pos_slow_reg, pos_slow_next;

    logic [CW-1:0] side_eff, large_eff, half_side;
    logic [PW-1:0] pf, pm, ps;
    logic          wrap;
    logic          last;
    logic          accept;

    function automatic logic [AW-1:0] slot_of(input logic [PW-1:0] p,
                                              input logic [CW-1:0] side,
                                              input logic [CW-1:0] klen,
                                              input logic [CW-1:0] half);
        logic [CW-1:0] idx;
        idx = (CW'(p) < half) ? CW'(p) : klen - side + CW'(p);
        if (idx >= CW'(MAX_KERNEL)) begin
            idx = '0;
        end
        return idx[AW-1:0];
    endfunction

    assign s_ready = !q_full;
    assign accept  = s_valid && s_ready;
    assign q_push  = accept;

    // Clamp the cube edge and kernel length into their legal ranges.
    always_comb begin
        side_eff = CW'(side_length);
        if (side_eff < CW'(2)) begin
            side_eff = CW'(2);
        end else if (side_eff > CW'(MAX_SIDE)) begin
            side_eff = CW'(MAX_SIDE);
        end
        side_eff[0] = 1'b0;
        half_side   = side_eff >> 1;

        large_eff = CW'(large_length);
        if (large_eff > CW'(MAX_KERNEL)) begin
            large_eff = CW'(MAX_KERNEL);
        end
        if (large_eff < side_eff) begin
            large_eff = side_eff;
        end
    end

    // Restart from the origin when the stored position lies outside the cube.
    always_comb begin
        wrap = (CW'(pos_fast_reg) >= side_eff) || (CW'(pos_mid_reg) >= side_eff) ||
               (CW'(pos_slow_reg) >= side_eff);
        pf = wrap ? '0 : pos_fast_reg;
        pm = wrap ? '0 : pos_mid_reg;
        ps = wrap ? '0 : pos_slow_reg;
        last = (CW'(pf) == side_eff - CW'(1)) && (CW'(pm) == side_eff - CW'(1)) &&
               (CW'(ps) == side_eff - CW'(1));
    end

    always_comb begin
        pos_fast_next = pos_fast_reg;
        pos_mid_next  = pos_mid_reg;
        pos_slow_next = pos_slow_reg;
        q_data        = '0;
        if (ssw_pkg::op_t'(s_operation) == ssw_pkg::OP_LOAD) begin
            pos_fast_next = '0;
            pos_mid_next  = '0;
            pos_slow_next = '0;
            q_data[OFF_OP]                      = ssw_pkg::OP_LOAD;
            q_data[OFF_OK]                      = 32'(s_weight_index) < 32'(MAX_KERNEL);
            q_data[OFF_S0 +: AW]                = AW'(s_weight_index);
            q_data[OFF_RE +: ssw_pkg::SAMPLE_W] = ssw_pkg::SAMPLE_W'(s_weight_re);
            q_data[OFF_IM +: ssw_pkg::SAMPLE_W] = ssw_pkg::SAMPLE_W'(s_weight_im);
        end else begin
            if (CW'(pf) + CW'(1) < side_eff) begin
                pos_fast_next = pf + PW'(1);
                pos_mid_next  = pm;
                pos_slow_next = ps;
            end else begin
                pos_fast_next = '0;
                if (CW'(pm) + CW'(1) < side_eff) begin
                    pos_mid_next  = pm + PW'(1);
                    pos_slow_next = ps;
                end else begin
                    pos_mid_next  = '0;
                    pos_slow_next = (CW'(ps) + CW'(1) < side_eff) ? ps + PW'(1) : '0;
                end
            end
            q_data[OFF_OP]                      = ssw_pkg::OP_WEIGHT;
            q_data[OFF_OK]                      = 1'b0;
            q_data[OFF_LAST]                    = last;
            q_data[OFF_S0 +: AW]                = slot_of(pf, side_eff, large_eff, half_side);
            q_data[OFF_S1 +: AW]                = slot_of(ps, side_eff, large_eff, half_side);
            q_data[OFF_S2 +: AW]                = slot_of(pm, side_eff, large_eff, half_side);
            q_data[OFF_RE +: ssw_pkg::SAMPLE_W] = s_sample_re;
            q_data[OFF_IM +: ssw_pkg::SAMPLE_W] = s_sample_im;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn || restart) begin
            pos_fast_reg <= '0;
            pos_mid_reg  <= '0;
            pos_slow_reg <= '0;
        end else if (accept) begin
            pos_fast_reg <= pos_fast_next;
            pos_mid_reg  <= pos_mid_next;
            pos_slow_reg <= pos_slow_next;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/ssw_back.sv =====
// Back end: executes queued commands, writes the kernel store and runs the
// three complex weightings of each sample. Depends on ssw_pkg and ssw_ram.
`timescale 1ns / 1ps
`default_nettype none

module ssw_back #(
    parameter int MAX_KERNEL       = 256,
    parameter int WEIGHT_FRAC_BITS = 16
) (
    input  wire logic                                aclk,
    input  wire logic                                aresetn,
    input  wire logic                                q_empty,
    input  wire logic [ssw_pkg::ENTRY_FIXED_W + 3*$clog2(MAX_KERNEL)-1:0] q_data,
    output      logic                                q_pop,
    output      logic                                m_valid,
    input  wire logic                                m_ready,
    output      logic signed [ssw_pkg::SAMPLE_W-1:0] m_result_re,
    output      logic signed [ssw_pkg::SAMPLE_W-1:0] m_result_im,
    output      logic                                m_last_of_volume,
    output      logic                                m_saturated
);

    localparam int AW    = $clog2(MAX_KERNEL);
    localparam int DW    = ssw_pkg::SAMPLE_W;
    localparam int WW    = ssw_pkg::WEIGHT_W;
    localparam int PRW   = ssw_pkg::PROD_W;
    localparam int SMW   = ssw_pkg::SUM_W;
    localparam int RW    = ssw_pkg::RND_W;

    localparam int OFF_IM   = 0;
    localparam int OFF_RE   = DW;
    localparam int OFF_S0   = 2 * DW;
    localparam int OFF_S1   = OFF_S0 + AW;
    localparam int OFF_S2   = OFF_S1 + AW;
    localparam int OFF_LAST = OFF_S2 + AW;
    localparam int OFF_OK   = OFF_LAST + 1;
    localparam int OFF_OP   = OFF_OK + 1;

    localparam logic [RW-1:0] ROUND_BIAS = RW'(1) << (WEIGHT_FRAC_BITS - 1);

    ssw_pkg::back_state_t state_reg, state_next;
    logic [1:0]           step_reg, step_next;
    logic [AW-1:0]        slot_reg [ssw_pkg::NUM_PASSES];
    logic [AW-1:0]        slot_next [ssw_pkg::NUM_PASSES];
    logic signed [DW-1:0] acc_re_reg, acc_re_next;
    logic signed [DW-1:0] acc_im_reg, acc_im_next;
    logic                 last_reg, last_next;
    logic                 sat_reg, sat_next;
    logic signed [PRW-1:0] p_rr_reg, p_rr_next;
    logic signed [PRW-1:0] p_ii_reg, p_ii_next;
    logic signed [PRW-1:0] p_ri_reg, p_ri_next;
    logic signed [PRW-1:0] p_ir_reg, p_ir_next;
    logic signed [SMW-1:0] sum_re_reg, sum_re_next;
    logic signed [SMW-1:0] sum_im_reg, sum_im_next;
    logic                 m_valid_reg, m_valid_next;
    logic [DW-1:0]        out_re_reg, out_re_next;
    logic [DW-1:0]        out_im_reg, out_im_next;
    logic                 out_last_reg, out_last_next;
    logic                 out_sat_reg, out_sat_next;

    logic                 ram_we;
    logic [AW-1:0]        ram_raddr;
    logic [2*WW-1:0]      ram_rdata;
    logic signed [WW-1:0] w_re, w_im;
    ssw_pkg::round_t      rnd_re, rnd_im;
    logic                 head_is_load;

    function automatic ssw_pkg::round_t round_sat(input logic signed [SMW-1:0] v);
        logic signed [RW-1:0] t;
        logic signed [RW-1:0] q;
        ssw_pkg::round_t      r;
        t = RW'(v) + $signed(ROUND_BIAS);
        q = t >>> WEIGHT_FRAC_BITS;
        if (!q[RW-1] && (|q[RW-2:DW-1])) begin
            r.value = ssw_pkg::SAMPLE_MAX;
            r.clip  = 1'b1;
        end else if (q[RW-1] && !(&q[RW-2:DW-1])) begin
            r.value = ssw_pkg::SAMPLE_MIN;
            r.clip  = 1'b1;
        end else begin
            r.value = q[DW-1:0];
            r.clip  = 1'b0;
        end
        return r;
    endfunction

    ssw_ram #(
        .WIDTH (2 * WW),
        .DEPTH (MAX_KERNEL)
    ) u_kernel_ram (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (q_data[OFF_S0 +: AW]),
        .wdata ({q_data[OFF_RE +: WW], q_data[OFF_IM +: WW]}),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign w_re         = $signed(ram_rdata[2*WW-1:WW]);
    assign w_im         = $signed(ram_rdata[WW-1:0]);
    assign rnd_re       = round_sat(sum_re_reg);
    assign rnd_im       = round_sat(sum_im_reg);
    assign head_is_load = (ssw_pkg::op_t'(q_data[OFF_OP]) == ssw_pkg::OP_LOAD);
    assign ram_raddr    = slot_reg[step_reg];

    always_comb begin
        state_next    = state_reg;
        step_next     = step_reg;
        slot_next     = slot_reg;
        acc_re_next   = acc_re_reg;
        acc_im_next   = acc_im_reg;
        last_next     = last_reg;
        sat_next      = sat_reg;
        p_rr_next     = p_rr_reg;
        p_ii_next     = p_ii_reg;
        p_ri_next     = p_ri_reg;
        p_ir_next     = p_ir_reg;
        sum_re_next   = sum_re_reg;
        sum_im_next   = sum_im_reg;
        out_re_next   = out_re_reg;
        out_im_next   = out_im_reg;
        out_last_next = out_last_reg;
        out_sat_next  = out_sat_reg;
        m_valid_next  = m_valid_reg && !m_ready;
        q_pop         = 1'b0;
        ram_we        = 1'b0;

        unique case (state_reg)
            ssw_pkg::BK_IDLE: begin
                if (!q_empty) begin
                    q_pop = 1'b1;
                    if (head_is_load) begin
                        ram_we = q_data[OFF_OK];
                    end else begin
                        acc_re_next  = $signed(q_data[OFF_RE +: DW]);
                        acc_im_next  = $signed(q_data[OFF_IM +: DW]);
                        slot_next[0] = q_data[OFF_S0 +: AW];
                        slot_next[1] = q_data[OFF_S1 +: AW];
                        slot_next[2] = q_data[OFF_S2 +: AW];
                        last_next    = q_data[OFF_LAST];
                        sat_next     = 1'b0;
                        step_next    = '0;
                        state_next   = ssw_pkg::BK_READ;
                    end
                end
            end
            ssw_pkg::BK_READ: begin
                state_next = ssw_pkg::BK_MUL;
            end
            ssw_pkg::BK_MUL: begin
                p_rr_next  = PRW'(acc_re_reg) * PRW'(w_re);
                p_ii_next  = PRW'(acc_im_reg) * PRW'(w_im);
                p_ri_next  = PRW'(acc_re_reg) * PRW'(w_im);
                p_ir_next  = PRW'(acc_im_reg) * PRW'(w_re);
                state_next = ssw_pkg::BK_ADD;
            end
            ssw_pkg::BK_ADD: begin
                sum_re_next = SMW'(p_rr_reg) - SMW'(p_ii_reg);
                sum_im_next = SMW'(p_ri_reg) + SMW'(p_ir_reg);
                state_next  = ssw_pkg::BK_RND;
            end
            ssw_pkg::BK_RND: begin
                acc_re_next = $signed(rnd_re.value);
                acc_im_next = $signed(rnd_im.value);
                sat_next    = sat_reg || rnd_re.clip || rnd_im.clip;
                if (step_reg == ssw_pkg::LAST_PASS) begin
                    state_next = ssw_pkg::BK_DONE;
                end else begin
                    step_next  = step_reg + 2'd1;
                    state_next = ssw_pkg::BK_READ;
                end
            end
            ssw_pkg::BK_DONE: begin
                if (!m_valid_reg || m_ready) begin
                    out_re_next   = acc_re_reg;
                    out_im_next   = acc_im_reg;
                    out_last_next = last_reg;
                    out_sat_next  = sat_reg;
                    m_valid_next  = 1'b1;
                    state_next    = ssw_pkg::BK_IDLE;
                end
            end
            default: begin
                state_next = ssw_pkg::BK_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ssw_pkg::BK_IDLE;
            step_reg    <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            step_reg    <= step_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        slot_reg     <= slot_next;
        acc_re_reg   <= acc_re_next;
        acc_im_reg   <= acc_im_next;
        last_reg     <= last_next;
        sat_reg      <= sat_next;
        p_rr_reg     <= p_rr_next;
        p_ii_reg     <= p_ii_next;
        p_ri_reg     <= p_ri_next;
        p_ir_reg     <= p_ir_next;
        sum_re_reg   <= sum_re_next;
        sum_im_reg   <= sum_im_next;
        out_re_reg   <= out_re_next;
        out_im_reg   <= out_im_next;
        out_last_reg <= out_last_next;
        out_sat_reg  <= out_sat_next;
    end

    assign m_valid          = m_valid_reg;
    assign m_result_re      = $signed(out_re_reg);
    assign m_result_im      = $signed(out_im_reg);
    assign m_last_of_volume = out_last_reg;
    assign m_saturated      = out_sat_reg;

    // The final pass hands over to the output stage, never back to a read.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ssw_pkg::BK_RND && step_reg == ssw_pkg::LAST_PASS)
        |=> state_reg == ssw_pkg::BK_DONE)
        else $error("ssw_back: final pass did not finish");

    // A finished sample waits while the output register is still occupied.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ssw_pkg::BK_DONE && m_valid_reg && !m_ready)
        |=> state_reg == ssw_pkg::BK_DONE)
        else $error("ssw_back: result overwrote a pending output");

    // Leaving the output stage always presents a result.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ssw_pkg::BK_DONE && state_next == ssw_pkg::BK_IDLE)
        |=> m_valid_reg)
        else $error("ssw_back: result lost on handover");

    // Commands leave the queue only between samples.
    assert property (@(posedge aclk) disable iff (!aresetn)
        q_pop |-> (state_reg == ssw_pkg::BK_IDLE && !q_empty))
        else $error("ssw_back: pop outside idle");

endmodule

`default_nettype wire

// ===== rtl/separable_spectral_weighting_unit.sv =====
// Separable spectral weighting unit: top level with configuration registers.
// A sample request passes through the command queue to the back end, which
// runs its single complex multiplier pass three times (read, multiply, add,
// round) and takes the next command only once the result is in the output
// register. A kernel load writes the store and gives no result.
// Reset (aresetn, synchronous): side 16, large 64, position at the origin,
// queue and output empty; the kernel store keeps its contents.
`timescale 1ns / 1ps
`default_nettype none

module separable_spectral_weighting_unit #(
    parameter int MAX_SIDE         = 64,
    parameter int MAX_KERNEL       = 256,
    parameter int WEIGHT_FRAC_BITS = 16
) (
    input  wire logic                                  aclk,
    input  wire logic                                  aresetn,
    // Configuration port
    input  wire logic                                  psel,
    input  wire logic                                  penable,
    input  wire logic                                  pwrite,
    input  wire logic [ssw_pkg::CFG_ADDR_W-1:0]        paddr,
    input  wire logic [ssw_pkg::CFG_DATA_W-1:0]        pwdata,
    output      logic [ssw_pkg::CFG_DATA_W-1:0]        prdata,
    output      logic                                  pready,
    // Request channel
    input  wire logic                                  s_valid,
    output      logic                                  s_ready,
    input  wire logic                                  s_operation,
    input  wire logic [ssw_pkg::WIDX_W-1:0]            s_weight_index,
    input  wire logic signed [ssw_pkg::WEIGHT_W-1:0]   s_weight_re,
    input  wire logic signed [ssw_pkg::WEIGHT_W-1:0]   s_weight_im,
    input  wire logic signed [ssw_pkg::SAMPLE_W-1:0]   s_sample_re,
    input  wire logic signed [ssw_pkg::SAMPLE_W-1:0]   s_sample_im,
    // Result channel
    output      logic                                  m_valid,
    input  wire logic                                  m_ready,
    output      logic signed [ssw_pkg::SAMPLE_W-1:0]   m_result_re,
    output      logic signed [ssw_pkg::SAMPLE_W-1:0]   m_result_im,
    output      logic                                  m_last_of_volume,
    output      logic                                  m_saturated
);

    localparam int AW = $clog2(MAX_KERNEL);
    localparam int EW = ssw_pkg::ENTRY_FIXED_W + 3 * AW;

    logic [ssw_pkg::SIDE_CFG_W-1:0]  side_length_reg, side_length_next;
    logic [ssw_pkg::LARGE_CFG_W-1:0] large_length_reg, large_length_next;
    logic                            cfg_write;
    ssw_pkg::cfg_reg_t               cfg_sel;

    logic          q_push, q_pop, q_full, q_empty;
    logic [EW-1:0] q_push_data, q_pop_data;

    // Configuration: the register index sits in the word-address bit.
    // Every write also restarts the volume position in the front end.
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;
    assign cfg_sel   = ssw_pkg::cfg_reg_t'(paddr[ssw_pkg::CFG_ADDR_W-1]);

    always_comb begin
        side_length_next  = side_length_reg;
        large_length_next = large_length_reg;
        prdata            = '0;
        unique case (cfg_sel)
            ssw_pkg::REG_SIDE: begin
                prdata = ssw_pkg::CFG_DATA_W'(side_length_reg);
                if (cfg_write) begin
                    side_length_next = pwdata[ssw_pkg::SIDE_CFG_W-1:0];
                end
            end
            ssw_pkg::REG_LARGE: begin
                prdata = ssw_pkg::CFG_DATA_W'(large_length_reg);
                if (cfg_write) begin
                    large_length_next = pwdata[ssw_pkg::LARGE_CFG_W-1:0];
                end
            end
            default: begin
                prdata = '0;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            side_length_reg  <= ssw_pkg::SIDE_RESET;
            large_length_reg <= ssw_pkg::LARGE_RESET;
        end else begin
            side_length_reg  <= side_length_next;
            large_length_reg <= large_length_next;
        end
    end

    // Front end: take each request as soon as the queue has room, advance
    // the cube position (back to the origin on a load) and resolve the kernel slots up front.
    ssw_front #(
        .MAX_SIDE   (MAX_SIDE),
        .MAX_KERNEL (MAX_KERNEL)
    ) u_front (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .restart        (cfg_write),
        .side_length    (side_length_reg),
        .large_length   (large_length_reg),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_operation    (s_operation),
        .s_weight_index (s_weight_index),
        .s_weight_re    (s_weight_re),
        .s_weight_im    (s_weight_im),
        .s_sample_re    (s_sample_re),
        .s_sample_im    (s_sample_im),
        .q_full         (q_full),
        .q_push         (q_push),
        .q_data         (q_push_data)
    );

    // Hold commands here so the front keeps accepting while the back end
    // works or waits on a stalled result.
    ssw_queue #(
        .WIDTH (EW),
        .DEPTH (ssw_pkg::QUEUE_DEPTH)
    ) u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (q_push),
        .push_data (q_push_data),
        .full      (q_full),
        .pop       (q_pop),
        .pop_data  (q_pop_data),
        .empty     (q_empty)
    );

    // Back end: write kernel weights in order with samples, then weight
    // each sample by the fast, slow and middle entries in turn.
    ssw_back #(
        .MAX_KERNEL       (MAX_KERNEL),
        .WEIGHT_FRAC_BITS (WEIGHT_FRAC_BITS)
    ) u_back (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .q_empty          (q_empty),
        .q_data           (q_pop_data),
        .q_pop            (q_pop),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_result_re      (m_result_re),
        .m_result_im      (m_result_im),
        .m_last_of_volume (m_last_of_volume),
        .m_saturated      (m_saturated)
    );

endmodule

`default_nettype wire

// ===== verif/tb_separable_spectral_weighting_unit.sv =====
// Testbench for the separable spectral weighting unit: kernel loads and sample
// weighting checked against an in-bench predictor. Depends on rtl/ssw_pkg.sv
// and the top level rtl/separable_spectral_weighting_unit.sv.
`timescale 1ns / 1ps

module tb_separable_spectral_weighting_unit;

    localparam int MAX_SIDE         = 64;
    localparam int MAX_KERNEL       = 256;
    localparam int WEIGHT_FRAC_BITS = 16;

    // Rounding constant and the signed 32-bit clipping bounds
    localparam longint HALF_LSB = longint'(1) <<< (WEIGHT_FRAC_BITS - 1);
    localparam longint SAT_HI   = 64'sh7FFF_FFFF;
    localparam longint SAT_LO   = -64'sh8000_0000;

    // Q7.16 weights used by the directed requests
    localparam logic [ssw_pkg::WEIGHT_W-1:0] W_MAX  = 24'h7F_FFFF;
    localparam logic [ssw_pkg::WEIGHT_W-1:0] W_MIN  = 24'h80_0000;
    localparam logic [ssw_pkg::WEIGHT_W-1:0] W_ONE  = 24'h01_0000;
    localparam logic [ssw_pkg::WEIGHT_W-1:0] W_HALF = 24'h00_8000;
    localparam int                           W_UNIT = 65536;

    localparam int RANDOM_ITEMS = 260;
    localparam int CALM_TAIL    = 80;    // last requests run with no idling at all
    localparam int ROUND_CAP    = 70;    // longest run of samples per round
    localparam int LONG_HOLD    = 300;   // receiver hold-off that backs up the queue
    localparam int DRAIN_CYCLES = 24;    // margin for loads still in the queue or back end
    localparam int QUIET_LIMIT  = 2000;  // cycles with no handshake before giving up
    localparam int PLAN_LEN     = 12;

    // Register settings walked by the random part; raw values, so the
    // clamping of side and large length is exercised (0, 1, odd, 127, 511...)
    logic [ssw_pkg::SIDE_CFG_W-1:0]  side_plan  [PLAN_LEN] = '{
        7'd2, 7'd4, 7'd0, 7'd127, 7'd7, 7'd1, 7'd64, 7'd3, 7'd4, 7'd6, 7'd2, 7'd16
    };
    logic [ssw_pkg::LARGE_CFG_W-1:0] large_plan [PLAN_LEN] = '{
        9'd2, 9'd9, 9'd0, 9'd511, 9'd20, 9'd256, 9'd64, 9'd1, 9'd300, 9'd6, 9'd100, 9'd64
    };

    // ------------------------------------------------------------------
    // Predictor and result store
    // ------------------------------------------------------------------
    class weighting_scoreboard;
        typedef struct {
            logic signed [ssw_pkg::SAMPLE_W-1:0] re;
            logic signed [ssw_pkg::SAMPLE_W-1:0] im;
            logic                                last;
            logic                                clip;
        } weighted_t;

        weighted_t                           awaited [$];
        logic signed [ssw_pkg::WEIGHT_W-1:0] kern_re [MAX_KERNEL];
        logic signed [ssw_pkg::WEIGHT_W-1:0] kern_im [MAX_KERNEL];
        logic [ssw_pkg::SIDE_CFG_W-1:0]      side_reg;
        logic [ssw_pkg::LARGE_CFG_W-1:0]     large_reg;
        int unsigned                         p_fast, p_mid, p_slow;
        int                                  errors, loads, checked, volume_ends, clipped;

        function new();
            side_reg  = ssw_pkg::SIDE_RESET;
            large_reg = ssw_pkg::LARGE_RESET;
            restart();
        endfunction

        function void restart();
            p_fast = 0;
            p_mid  = 0;
            p_slow = 0;
        endfunction

        function int pending();
            return awaited.size();
        endfunction

        // Clamp to 2..MAX_SIDE, then drop to even
        function int unsigned side_eff();
            int unsigned s;
            s = side_reg;
            if (s < 2) s = 2;
            if (s > MAX_SIDE) s = MAX_SIDE;
            return s & ~32'd1;
        endfunction

        function int unsigned large_eff(int unsigned s);
            int unsigned l;
            l = large_reg;
            if (l > MAX_KERNEL) l = MAX_KERNEL;
            if (l < s) l = s;
            return l;
        endfunction

        // Low half of the positions read the low frequencies, the rest the top end
        function int unsigned slot(int unsigned p, int unsigned s, int unsigned l);
            return (p < s / 2) ? p : l - s + p;
        endfunction

        function logic signed [ssw_pkg::SAMPLE_W-1:0] round_clip(longint v,
                                                                 inout logic clip);
            longint q;
            q = (v + HALF_LSB) >>> WEIGHT_FRAC_BITS;
            if (q > SAT_HI) begin
                clip = 1'b1;
                return ssw_pkg::SAMPLE_MAX;
            end
            if (q < SAT_LO) begin
                clip = 1'b1;
                return ssw_pkg::SAMPLE_MIN;
            end
            return q[ssw_pkg::SAMPLE_W-1:0];
        endfunction

        function void weigh(inout logic signed [ssw_pkg::SAMPLE_W-1:0] re,
                            inout logic signed [ssw_pkg::SAMPLE_W-1:0] im,
                            input int unsigned k, inout logic clip);
            longint a, b, wr, wi, pr, pi;
            a  = re;
            b  = im;
            wr = kern_re[k];
            wi = kern_im[k];
            pr = a * wr - b * wi;
            pi = a * wi + b * wr;
            re = round_clip(pr, clip);
            im = round_clip(pi, clip);
        endfunction

        function void note_config(ssw_pkg::cfg_reg_t r,
                                  logic [ssw_pkg::CFG_DATA_W-1:0] d);
            if (r == ssw_pkg::REG_SIDE) side_reg = d[ssw_pkg::SIDE_CFG_W-1:0];
            else large_reg = d[ssw_pkg::LARGE_CFG_W-1:0];
            restart();
        endfunction

        function void note_request(ssw_pkg::op_t op, logic [ssw_pkg::WIDX_W-1:0] idx,
                                   logic signed [ssw_pkg::WEIGHT_W-1:0] wr,
                                   logic signed [ssw_pkg::WEIGHT_W-1:0] wi,
                                   logic signed [ssw_pkg::SAMPLE_W-1:0] sr,
                                   logic signed [ssw_pkg::SAMPLE_W-1:0] si);
            int unsigned s, l;
            logic signed [ssw_pkg::SAMPLE_W-1:0] re, im;
            logic clip;
            weighted_t res;
            if (op == ssw_pkg::OP_LOAD) begin
                kern_re[idx] = wr;
                kern_im[idx] = wi;
                loads++;
                restart();
                return;
            end
            s = side_eff();
            l = large_eff(s);
            if (p_fast >= s || p_mid >= s || p_slow >= s) restart();
            re   = sr;
            im   = si;
            clip = 1'b0;
            // Product order: fast axis, then slow, then middle
            weigh(re, im, slot(p_fast, s, l), clip);
            weigh(re, im, slot(p_slow, s, l), clip);
            weigh(re, im, slot(p_mid, s, l), clip);
            res.re   = re;
            res.im   = im;
            res.clip = clip;
            res.last = (p_fast == s - 1 && p_mid == s - 1 && p_slow == s - 1);
            awaited.push_back(res);
            if (p_fast + 1 < s) begin
                p_fast++;
            end else begin
                p_fast = 0;
                if (p_mid + 1 < s) begin
                    p_mid++;
                end else begin
                    p_mid  = 0;
                    p_slow = (p_slow + 1 < s) ? p_slow + 1 : 0;
                end
            end
        endfunction

        function void compare(string field, logic signed [63:0] want,
                              logic signed [63:0] got);
            if (want !== got) begin
                $error("%s: expected %0d, got %0d", field, want, got);
                errors++;
            end
        endfunction

        function void check_result(logic signed [ssw_pkg::SAMPLE_W-1:0] re,
                                   logic signed [ssw_pkg::SAMPLE_W-1:0] im,
                                   logic last, logic sat);
            weighted_t want;
            if (awaited.size() == 0) begin
                $error("result with no sample outstanding: re %0d im %0d", re, im);
                errors++;
                return;
            end
            want = awaited.pop_front();
            checked++;
            if (want.last) volume_ends++;
            if (want.clip) clipped++;
            compare("result_re", want.re, re);
            compare("result_im", want.im, im);
            compare("last_of_volume", want.last, last);
            compare("saturated", want.clip, sat);
        endfunction
    endclass

    // ------------------------------------------------------------------
    // Clock, reset and the signals around the block
    // ------------------------------------------------------------------
    logic aclk    = 1'b0;
    logic aresetn = 1'b0;

    always begin
        #10 aclk = 1'b1;
        #10 aclk = 1'b0;
    end

    logic                               psel    = 1'b0;
    logic                               penable = 1'b0;
    logic                               pwrite  = 1'b0;
    logic [ssw_pkg::CFG_ADDR_W-1:0]     paddr   = '0;
    logic [ssw_pkg::CFG_DATA_W-1:0]     pwdata  = '0;
    logic [ssw_pkg::CFG_DATA_W-1:0]     prdata;
    logic                               pready;

    logic                                s_valid        = 1'b0;
    logic                                s_ready;
    logic                                s_operation    = 1'b0;
    logic [ssw_pkg::WIDX_W-1:0]          s_weight_index = '0;
    logic signed [ssw_pkg::WEIGHT_W-1:0] s_weight_re    = '0;
    logic signed [ssw_pkg::WEIGHT_W-1:0] s_weight_im    = '0;
    logic signed [ssw_pkg::SAMPLE_W-1:0] s_sample_re    = '0;
    logic signed [ssw_pkg::SAMPLE_W-1:0] s_sample_im    = '0;

    logic                                m_valid;
    logic                                m_ready = 1'b0;
    logic signed [ssw_pkg::SAMPLE_W-1:0] m_result_re;
    logic signed [ssw_pkg::SAMPLE_W-1:0] m_result_im;
    logic                                m_last_of_volume;
    logic                                m_saturated;

    separable_spectral_weighting_unit #(
        .MAX_SIDE         (MAX_SIDE),
        .MAX_KERNEL       (MAX_KERNEL),
        .WEIGHT_FRAC_BITS (WEIGHT_FRAC_BITS)
    ) dut (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .psel             (psel),
        .penable          (penable),
        .pwrite           (pwrite),
        .paddr            (paddr),
        .pwdata           (pwdata),
        .prdata           (prdata),
        .pready           (pready),
        .s_valid          (s_valid),
        .s_ready          (s_ready),
        .s_operation      (s_operation),
        .s_weight_index   (s_weight_index),
        .s_weight_re      (s_weight_re),
        .s_weight_im      (s_weight_im),
        .s_sample_re      (s_sample_re),
        .s_sample_im      (s_sample_im),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_result_re      (m_result_re),
        .m_result_im      (m_result_im),
        .m_last_of_volume (m_last_of_volume),
        .m_saturated      (m_saturated)
    );

    weighting_scoreboard sb = new();

    bit idle_on       = 1'b0;  // both sides may idle in random bursts
    bit long_hold_req = 1'b0;  // ask the receiver for one long hold-off
    int sent_requests = 0;

    // ------------------------------------------------------------------
    // Monitor: sample handshakes on the pre-edge values, feed the
    // predictor and the checker, and run the watchdog.
    // ------------------------------------------------------------------
    always @(posedge aclk) begin
        int quiet;
        if (aresetn) begin
            // Registers sit at byte address 4*i; other addresses are never written
            if (psel && penable && pwrite && pready && paddr[1:0] == 2'b00)
                sb.note_config(ssw_pkg::cfg_reg_t'(paddr[2]), pwdata);
            if (s_valid && s_ready)
                sb.note_request(ssw_pkg::op_t'(s_operation), s_weight_index,
                                s_weight_re, s_weight_im, s_sample_re, s_sample_im);
            if (m_valid && m_ready)
                sb.check_result(m_result_re, m_result_im, m_last_of_volume, m_saturated);
            if ((s_valid && s_ready) || (m_valid && m_ready) || (psel && penable))
                quiet = 0;
            else
                quiet++;
            if (quiet >= QUIET_LIMIT) begin
                $display("tb_separable_spectral_weighting_unit: errors");
                $finish;
            end
        end
    end

    // ------------------------------------------------------------------
    // Receiver: short random stalls while idling is on, one long hold
    // on request so the command queue fills and s_ready drops.
    // ------------------------------------------------------------------
    initial begin
        int stall;
        stall = 0;
        forever begin
            @(posedge aclk);
            if (stall > 0) begin
                stall--;
                m_ready <= 1'b0;
            end else if (long_hold_req) begin
                long_hold_req = 1'b0;
                stall = LONG_HOLD - 1;
                m_ready <= 1'b0;
            end else if (idle_on && $urandom_range(0, 5) == 0) begin
                stall = $urandom_range(0, 8);
                m_ready <= 1'b0;
            end else begin
                m_ready <= 1'b1;
            end
        end
    end

    // ------------------------------------------------------------------
    // Drivers; every task is entered right after a rising edge
    // ------------------------------------------------------------------

    // Setup cycle, access cycle; the register takes the value at the access
    // edge, where the monitor records it as well. The task then idles the bus.
    task automatic write_config(ssw_pkg::cfg_reg_t r,
                                logic [ssw_pkg::CFG_DATA_W-1:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {r, 2'b00};
        pwdata  <= value;
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge aclk);
    endtask

    // Offer one request, optionally after an idle burst, and hold it until taken
    task automatic send_request(ssw_pkg::op_t op, logic [ssw_pkg::WIDX_W-1:0] idx,
                                logic [ssw_pkg::WEIGHT_W-1:0] wr,
                                logic [ssw_pkg::WEIGHT_W-1:0] wi,
                                logic [ssw_pkg::SAMPLE_W-1:0] sr,
                                logic [ssw_pkg::SAMPLE_W-1:0] si);
        if (idle_on && $urandom_range(0, 4) == 0) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 9)) @(posedge aclk);
        end
        s_valid        <= 1'b1;
        s_operation    <= op;
        s_weight_index <= idx;
        s_weight_re    <= wr;
        s_weight_im    <= wi;
        s_sample_re    <= sr;
        s_sample_im    <= si;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        sent_requests++;
    endtask

    // Unused fields of a request still toggle so every input bit moves
    task automatic load_weight(logic [ssw_pkg::WIDX_W-1:0] idx,
                               logic [ssw_pkg::WEIGHT_W-1:0] wr,
                               logic [ssw_pkg::WEIGHT_W-1:0] wi);
        send_request(ssw_pkg::OP_LOAD, idx, wr, wi, $urandom, $urandom);
    endtask

    task automatic weigh_sample(logic [ssw_pkg::SAMPLE_W-1:0] sr,
                                logic [ssw_pkg::SAMPLE_W-1:0] si);
        send_request(ssw_pkg::OP_WEIGHT, ssw_pkg::WIDX_W'($urandom),
                     ssw_pkg::WEIGHT_W'($urandom), ssw_pkg::WEIGHT_W'($urandom),
                     sr, si);
    endtask

    // Wait out every result and any load still in flight before a register write
    task automatic settle();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (sb.pending() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    // Mostly gains within +-1.0 so that not every sample clips; a quarter full range
    function automatic logic [ssw_pkg::WEIGHT_W-1:0] random_weight();
        int v;
        if ($urandom_range(0, 3) == 0) return ssw_pkg::WEIGHT_W'($urandom);
        v = int'($urandom_range(0, 2 * W_UNIT)) - W_UNIT;
        return ssw_pkg::WEIGHT_W'(v);
    endfunction

    function automatic logic [ssw_pkg::SAMPLE_W-1:0] random_sample();
        int v;
        if ($urandom_range(0, 3) != 0) return $urandom;
        v = int'($urandom_range(0, 4000)) - 2000;
        return ssw_pkg::SAMPLE_W'(v);
    endfunction

    // ------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------
    initial begin
        int random_start, settings, vol, round_len;
        bit pressed;
        settings = 0;
        pressed  = 1'b0;

        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        idle_on = 1'b1;

        // The kernel store powers up undefined: fill every entry before any
        // sample can read it. Reset values stay in force (side 16, large 64).
        for (int i = 0; i < MAX_KERNEL; i++)
            load_weight(ssw_pkg::WIDX_W'(i), random_weight(), random_weight());

        // Directed part. Each load puts the position back at the origin, so
        // the sample right after it reads entry 0 on all three axes.
        load_weight('0, W_MAX, W_MAX);                  // largest gain: clips
        weigh_sample(ssw_pkg::SAMPLE_MAX, ssw_pkg::SAMPLE_MAX);
        load_weight('0, W_MIN, W_MIN);                  // most negative weight
        weigh_sample(ssw_pkg::SAMPLE_MIN, ssw_pkg::SAMPLE_MIN);
        load_weight('0, W_ONE, '0);                     // unit gain: exact pass-through
        weigh_sample(ssw_pkg::SAMPLE_MIN, ssw_pkg::SAMPLE_MAX);
        load_weight('0, '0, W_ONE);                     // j cubed sends -2^31 past the top: clips
        weigh_sample(ssw_pkg::SAMPLE_MIN, '0);
        load_weight('0, W_HALF, '0);                    // halves tie and round upward
        weigh_sample(32'sd1, -32'sd1);
        load_weight('0, '0, '0);                        // zero weight
        weigh_sample(ssw_pkg::SAMPLE_MAX, ssw_pkg::SAMPLE_MIN);
        load_weight(8'hFF, random_weight(), random_weight());  // top entry of the store
        repeat (4) weigh_sample(random_sample(), random_sample());

        // Random part: walk the register plan; each setting gets two rounds,
        // a round being a whole volume of samples where that is short enough.
        random_start = sent_requests;
        while (sent_requests - random_start < RANDOM_ITEMS) begin
            settle();
            write_config(ssw_pkg::REG_SIDE,
                         ssw_pkg::CFG_DATA_W'(side_plan[settings % PLAN_LEN]));
            write_config(ssw_pkg::REG_LARGE,
                         ssw_pkg::CFG_DATA_W'(large_plan[settings % PLAN_LEN]));
            settings++;
            repeat (2) begin
                idle_on = (sent_requests - random_start < RANDOM_ITEMS - CALM_TAIL) &&
                          ($urandom_range(0, 3) != 0);
                vol = sb.side_eff() ** 3;
                round_len = (vol <= ROUND_CAP) ? vol : $urandom_range(20, 50);
                // Once, stall the receiver and keep feeding until the input backs up
                if (!pressed && sent_requests - random_start > 150 && round_len >= 20) begin
                    pressed = 1'b1;
                    idle_on = 1'b0;
                    long_hold_req = 1'b1;
                end
                for (int n = 0; n < round_len; n++) begin
                    // Rare stray load breaks the volume mid-way
                    if ($urandom_range(0, 119) == 0)
                        load_weight(ssw_pkg::WIDX_W'($urandom), random_weight(),
                                    random_weight());
                    weigh_sample(random_sample(), random_sample());
                end
                if ($urandom_range(0, 1) == 0)
                    load_weight(ssw_pkg::WIDX_W'($urandom), random_weight(),
                                random_weight());
            end
        end

        // Drain, then leave room for anything spurious to show up
        settle();
        repeat (40) @(posedge aclk);

        $display("Run covered %0d requests (%0d kernel loads) over %0d register settings;",
                 sent_requests, sb.loads, settings + 1);
        $display("%0d weighted samples checked, %0d volume ends, %0d clipped.",
                 sb.checked, sb.volume_ends, sb.clipped);
        if (sb.errors == 0 && sb.pending() == 0) begin
            $display("tb_separable_spectral_weighting_unit: clean");
        end else begin
            $display("tb_separable_spectral_weighting_unit: errors");
        end
        $finish;
    end

endmodule
